// ===== hw/rtl/missing_block_tracker_assert.svh =====
// Assertion macros for the missing block tracker.
// Takes no other file. The clock is aclk, and the reset is aresetn, active low.
`ifndef MISSING_BLOCK_TRACKER_ASSERT_SVH
`define MISSING_BLOCK_TRACKER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MBT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbt_pkg.sv =====
// Shared constants, codes and the result struct for the missing block tracker.
// Takes no other file. The sequencer and the top level use it.
package mbt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BLK_W       = 31;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 72;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Input selector (s_tuser).
    localparam logic OP_BLOCK  = 1'b0;
    localparam logic OP_STATUS = 1'b1;

    // Result kind (m_tuser).
    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_DUMP    = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [BLK_W-1:0] highest;
        logic             req;
        logic             matched;
        logic             ovf;
        logic [BLK_W-1:0] entry;
        logic             last;
    } res_t;

endpackage

// ===== hw/rtl/mbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Takes no other file.
module mbt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/mbt_seq.sv =====
// Sequencer of the missing block tracker: holds the slot table in a RAM,
// sweeps it for gap fill, match clear and status dump. Uses mbt_pkg, mbt_ram.
module mbt_seq (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_op,
    input  logic [mbt_pkg::BLK_W-1:0] in_blk,
    output logic                     res_valid,
    input  logic                     res_ready,
    output mbt_pkg::res_t            res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ARR_OUT,
        ST_DUMP
    } state_t;

    state_t                      state_reg, state_next;
    logic [mbt_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [mbt_pkg::BLK_W-1:0]   blk_reg, blk_next;
    logic [mbt_pkg::BLK_W-1:0]   hi_reg, hi_next;
    logic [mbt_pkg::BLK_W-1:0]   fill_reg, fill_next;   // next number to place
    logic                        ins_reg, ins_next;
    logic                        clr_reg, clr_next;
    logic                        matched_reg, matched_next;
    logic [mbt_pkg::TABLE_DEPTH-1:0] vld_reg, vld_next;

    logic                        ram_we;
    logic [mbt_pkg::BLK_W-1:0]   ram_wdata;
    logic [mbt_pkg::BLK_W-1:0]   ram_rdata;
    logic [mbt_pkg::BLK_W-1:0]   entry;
    logic [mbt_pkg::IDX_W-1:0]   idx_inc;
    logic                        at_last;

    mbt_ram #(
        .WIDTH (mbt_pkg::BLK_W),
        .DEPTH (mbt_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // Slots never written since reset read as free.
    assign entry   = vld_reg[idx_reg] ? ram_rdata : '0;
    assign at_last = (idx_reg == mbt_pkg::LAST_IDX);
    assign idx_inc = at_last ? '0 : idx_reg + mbt_pkg::IDX_W'(1);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        blk_next     = blk_reg;
        hi_next      = hi_reg;
        fill_next    = fill_reg;
        ins_next     = ins_reg;
        clr_next     = clr_reg;
        matched_next = matched_reg;
        vld_next     = vld_reg;
        ram_we       = 1'b0;
        ram_wdata    = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        res.highest  = hi_reg;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                idx_next = '0;
                if (in_valid) begin
                    if (in_op == mbt_pkg::OP_STATUS) begin
                        state_next = ST_DUMP;
                    end else begin
                        blk_next     = in_blk;
                        ins_next     = ({1'b0, in_blk} > ({1'b0, hi_reg} + 32'd1));
                        clr_next     = (in_blk <= hi_reg) && (in_blk != '0);
                        fill_next    = hi_reg + mbt_pkg::BLK_W'(1);
                        matched_next = 1'b0;
                        if (in_blk > hi_reg) begin
                            hi_next = in_blk;
                        end
                        if (({1'b0, in_blk} > ({1'b0, hi_reg} + 32'd1)) ||
                            ((in_blk <= hi_reg) && (in_blk != '0))) begin
                            state_next = ST_SWEEP;
                        end else begin
                            state_next = ST_ARR_OUT;
                        end
                    end
                end
            end

            ST_SWEEP: begin
                if (ins_reg && (fill_reg != blk_reg) && (entry == '0)) begin
                    ram_we            = 1'b1;
                    ram_wdata         = fill_reg;
                    vld_next[idx_reg] = 1'b1;
                    fill_next         = fill_reg + mbt_pkg::BLK_W'(1);
                end else if (clr_reg && !matched_reg && (entry == blk_reg)) begin
                    ram_we            = 1'b1;
                    ram_wdata         = '0;
                    vld_next[idx_reg] = 1'b1;
                    matched_next      = 1'b1;
                end
                idx_next = idx_inc;
                if (at_last) begin
                    state_next = ST_ARR_OUT;
                end
            end

            ST_ARR_OUT: begin
                res_valid   = 1'b1;
                res.kind    = mbt_pkg::KIND_ARRIVAL;
                res.req     = ins_reg;
                res.matched = matched_reg;
                res.ovf     = ins_reg && (fill_reg != blk_reg);
                res.last    = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP: begin
                res_valid = 1'b1;
                res.kind  = mbt_pkg::KIND_DUMP;
                res.entry = entry;
                res.last  = at_last;
                if (res_ready) begin
                    idx_next = idx_inc;
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            hi_reg      <= '0;
            vld_reg     <= '0;
            ins_reg     <= 1'b0;
            clr_reg     <= 1'b0;
            matched_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hi_reg      <= hi_next;
            vld_reg     <= vld_next;
            ins_reg     <= ins_next;
            clr_reg     <= clr_next;
            matched_reg <= matched_next;
        end
        blk_reg  <= blk_next;
        fill_reg <= fill_next;
    end

endmodule

// ===== hw/rtl/missing_block_tracker.sv =====
// Top level of the missing block tracker: stream ports and the output register.
// Uses mbt_pkg, mbt_seq (with mbt_ram) and missing_block_tracker_assert.svh.
//
// Usage:
//  - Input channel s_*: one transfer per request. s_tuser is the op (block
//    arrived or status request), and s_tdata[30:0] is the block number.
//  - Result channel m_*: m_tuser is the kind (arrival result or dump entry),
//    m_tlast marks the final result of a request, and m_tdata carries the
//    highest block, the request, match and overflow flags, and the slot value.
//  - A block arrival that fills a gap or clears an old entry walks all
//    TABLE_DEPTH slots of the table RAM, one slot per cycle, before it gives
//    its single result. A block one past the highest, or a block zero, skips
//    the walk.
//  - A status request streams TABLE_DEPTH transfers, one per cycle while
//    m_tready is high.
//  - Only one request is in flight. s_tready is high only while the sequencer
//    is idle, so a new request waits until the last result has been handed on.
//  - Reset clears the highest block and the slot valid bits, so every slot
//    reads as free at once. No clearing pass is needed.
//  - When m_tready is low, the output register holds its transfer. A dump
//    pauses on its current slot and nothing is lost.
`include "missing_block_tracker_assert.svh"

module missing_block_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: [30:0] block_number, [31] zero pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbt_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: [0] op
    input  logic [0:0]                      s_tuser,
    // m_tdata: [30:0] highest_block, [31] request_needed,
    //          [32] retransmit_matched, [33] table_overflow,
    //          [64:34] entry_value, [71:65] zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbt_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: [0] kind
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast
);

    logic          res_valid;
    logic          res_ready;
    mbt_pkg::res_t res;

    logic          m_tvalid_reg;
    mbt_pkg::res_t out_reg;

    mbt_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_blk    (s_tdata[mbt_pkg::BLK_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.entry, out_reg.ovf, out_reg.matched, out_reg.req,
                       out_reg.highest};

    // An accepted block arrival leaves the sequencer busy, so s_tready goes low.
    `MBT_ASSERT_NEXT(a_arrival_busy,
        s_tvalid && s_tready && (s_tuser[0] == mbt_pkg::OP_BLOCK), !s_tready,
        "input taken right after a block arrival")
    // A dump in progress blocks new input.
    `MBT_ASSERT_SAME(a_dump_blocks,
        m_tvalid && (m_tuser[0] == mbt_pkg::KIND_DUMP) && !m_tlast, !s_tready,
        "input ready during a status dump")
    // An arrival result is a single, final transfer with an empty slot field.
    `MBT_ASSERT_SAME(a_arrival_shape,
        m_tvalid && (m_tuser[0] == mbt_pkg::KIND_ARRIVAL),
        m_tlast && (m_tdata[64:34] == '0),
        "malformed arrival result")
    // Overflow only comes with a gap, and a gap never clears an entry.
    `MBT_ASSERT_SAME(a_flag_consistency,
        m_tvalid && (m_tdata[33] || m_tdata[32]),
        (m_tdata[33] == 1'b0 || m_tdata[31] == 1'b1) && !(m_tdata[31] && m_tdata[32]),
        "inconsistent arrival flags")

endmodule
